/* rtl/core/psrt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrt_pkg
// Constants and register codes shared by the point transform pipeline.
// ----------------------------------------------------------------------------
package psrt_pkg;

	localparam int COORD_WIDTH_DEF = 32;

	// configuration port
	localparam int CFG_W   = 60;
	localparam int INDEX_W = 3;

	typedef enum logic [INDEX_W-1:0] {
		REG_ROT_ROW0 = 3'd0,
		REG_ROT_ROW1 = 3'd1,
		REG_ROT_ROW2 = 3'd2,
		REG_SCALE    = 3'd3,
		REG_OFFSET_X = 3'd4,
		REG_OFFSET_Y = 3'd5,
		REG_OFFSET_Z = 3'd6
	} reg_index_t;

	// field layout
	localparam int ROW_W   = 54;
	localparam int ENT_W   = 18;
	localparam int SCALE_W = 20;
	localparam int FRAC_W  = 16;

	localparam logic [ROW_W-1:0]  ROT_ROW0_RST = 54'd65536;
	localparam logic [ROW_W-1:0]  ROT_ROW1_RST = 54'd17179869184;
	localparam logic [ROW_W-1:0]  ROT_ROW2_RST = 54'd4503599627370496;
	localparam logic [CFG_W-1:0]  SCALE_RST    = 60'd72057662757470208;

	localparam int ROUND_HALF = 32768;

	// normal renormalization
	localparam int NORM_MSB  = 29;
	localparam int NORM_W    = 30;
	localparam int SQ_W      = 60;
	localparam int L2_W      = 62;
	localparam int SQ_STEPS  = 31;
	localparam int LEN_W     = 31;
	localparam int Q_BITS    = 17;
	localparam int DREM_W    = 47;

endpackage

/* rtl/core/point_scale_rotate_translate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_scale_rotate_translate
// Per-point scale, 3x3 rotation and translation with normal renormalization.
// ----------------------------------------------------------------------------
// Takes one point word per cycle and returns one result word per input word,
// in order. The path is a fixed pipeline of seven stages:
// scale and normal products, rounding, rotation products, sum, translate and
// saturate beside a leading-one search, shift, squaring and squared length.
// After those come a 31-stage bit-per-stage square root, a 17-stage
// bit-per-stage divider for the unit normal and the output register.
// The whole pipeline advances whenever the output word is empty or being
// taken, so m_tready low stalls every stage at once.
// Write the configuration registers only while no word is in flight.
module point_scale_rotate_translate #(
	parameter int COORD_WIDTH = psrt_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [psrt_pkg::INDEX_W-1:0]  wr_index,
	input  logic [psrt_pkg::CFG_W-1:0]    wr_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	// has_normal, in_group
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z
	output logic [((6*COORD_WIDTH+7)/8)*8-1:0] m_tdata
);

	localparam int W      = COORD_WIDTH;
	localparam int DW     = ((6*W+7)/8)*8;
	localparam int FW     = psrt_pkg::FRAC_W;
	localparam int EW     = psrt_pkg::ENT_W;
	localparam int SW     = psrt_pkg::SCALE_W;
	localparam int UW     = W + 4;
	localparam int PW     = $clog2(UW);
	localparam int NW     = psrt_pkg::NORM_W;
	localparam int L2W    = psrt_pkg::L2_W;
	localparam int NSQ    = psrt_pkg::SQ_STEPS;
	localparam int LW     = psrt_pkg::LEN_W;
	localparam int QB     = psrt_pkg::Q_BITS;
	localparam int RW     = psrt_pkg::DREM_W;
	localparam int DEPTH  = 7 + NSQ + QB + 1;

	typedef struct packed {
		logic [2:0][W-1:0] pos;
		logic [2:0][W-1:0] norm;
		logic              use_q;
		logic [2:0]        neg;
	} side_t;

	// ---------------- configuration ----------------
	logic [psrt_pkg::ROW_W-1:0] rot_q [3];
	logic [psrt_pkg::CFG_W-1:0] scale_q;
	logic [W-1:0]               off_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= psrt_pkg::ROT_ROW0_RST;
			rot_q[1] <= psrt_pkg::ROT_ROW1_RST;
			rot_q[2] <= psrt_pkg::ROT_ROW2_RST;
			scale_q  <= psrt_pkg::SCALE_RST;
			off_q[0] <= '0;
			off_q[1] <= '0;
			off_q[2] <= '0;
		end else if (wr_en) begin
			unique case (psrt_pkg::reg_index_t'(wr_index))
				psrt_pkg::REG_ROT_ROW0: rot_q[0] <= wr_data[psrt_pkg::ROW_W-1:0];
				psrt_pkg::REG_ROT_ROW1: rot_q[1] <= wr_data[psrt_pkg::ROW_W-1:0];
				psrt_pkg::REG_ROT_ROW2: rot_q[2] <= wr_data[psrt_pkg::ROW_W-1:0];
				psrt_pkg::REG_SCALE:    scale_q  <= wr_data;
				psrt_pkg::REG_OFFSET_X: off_q[0] <= wr_data[W-1:0];
				psrt_pkg::REG_OFFSET_Y: off_q[1] <= wr_data[W-1:0];
				psrt_pkg::REG_OFFSET_Z: off_q[2] <= wr_data[W-1:0];
				default: ;
			endcase
		end
	end

	logic signed [EW-1:0] mat [3][3];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				mat[r][c] = $signed(rot_q[r][EW*c +: EW]);
			end
		end
	end

	// ---------------- flow control ----------------
	logic             ce;
	logic [DEPTH-1:0] vld_s;

	assign ce       = !vld_s[DEPTH-1] || m_tready;
	assign s_tready = ce;
	assign m_tvalid = vld_s[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[DEPTH-2:0], s_tvalid};
		end
	end

	// ---------------- stage 1: scale and normal products ----------------
	logic signed [W-1:0]    in_p [3];
	logic signed [W-1:0]    in_n [3];
	logic signed [W+20:0]   ps_s1 [3];
	logic signed [W+17:0]   nm_s1 [3][3];
	logic [W-1:0]           p_s1 [3];
	logic [W-1:0]           n_s1 [3];
	logic                   hasn_s1, grp_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_p[i] = $signed(s_tdata[W*i +: W]);
			in_n[i] = $signed(s_tdata[W*(3+i) +: W]);
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				ps_s1[i] <= (W+21)'(in_p[i]) *
					(W+21)'($signed({1'b0, scale_q[SW*i +: SW]}));
				for (int c = 0; c < 3; c++) begin
					nm_s1[i][c] <= (W+18)'(in_n[c]) * (W+18)'(mat[i][c]);
				end
				p_s1[i] <= in_p[i];
				n_s1[i] <= in_n[i];
			end
			hasn_s1 <= s_tuser[0];
			grp_s1  <= s_tuser[1];
		end
	end

	// ---------------- stage 2: round scaled position, rotated normal ----------------
	logic signed [W+20:0] ps_rnd [3];
	logic signed [W+19:0] nsum [3];
	logic signed [W+4:0]  sc_s2 [3];
	logic signed [W+3:0]  r_s2 [3];
	logic [W-1:0]         p_s2 [3];
	logic [W-1:0]         n_s2 [3];
	logic                 hasn_s2, grp_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ps_rnd[i] = ps_s1[i] + (W+21)'(psrt_pkg::ROUND_HALF);
			nsum[i]   = (W+20)'(nm_s1[i][0]) + (W+20)'(nm_s1[i][1])
				+ (W+20)'(nm_s1[i][2]) + (W+20)'(psrt_pkg::ROUND_HALF);
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				sc_s2[i] <= $signed(ps_rnd[i][W+20:FW]);
				r_s2[i]  <= $signed(nsum[i][W+19:FW]);
				p_s2[i]  <= p_s1[i];
				n_s2[i]  <= n_s1[i];
			end
			hasn_s2 <= hasn_s1;
			grp_s2  <= grp_s1;
		end
	end

	// ---------------- stage 3: rotation products, normal magnitudes ----------------
	logic signed [W+22:0] sp_s3 [3][3];
	logic [UW-1:0]        u_s3 [3];
	logic [2:0]           neg_s3;
	logic [W-1:0]         p_s3 [3];
	logic [W-1:0]         n_s3 [3];
	logic                 hasn_s3, grp_s3;

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				for (int c = 0; c < 3; c++) begin
					sp_s3[i][c] <= (W+23)'(sc_s2[c]) * (W+23)'(mat[i][c]);
				end
				neg_s3[i] <= r_s2[i][W+3];
				u_s3[i]   <= r_s2[i][W+3] ? UW'(-r_s2[i]) : UW'(r_s2[i]);
				p_s3[i]   <= p_s2[i];
				n_s3[i]   <= n_s2[i];
			end
			hasn_s3 <= hasn_s2;
			grp_s3  <= grp_s2;
		end
	end

	// ---------------- stage 4: sum, round, translate, saturate; leading one ----------------
	logic signed [W+25:0] psum [3];
	logic [W+9:0]         prnd [3];
	logic [W-1:0]         psat [3];
	logic [UW-1:0]        u_or;
	logic [PW-1:0]        msb_pos;
	side_t                side_d4;
	side_t                side_s4;
	logic [UW-1:0]        u_s4 [3];
	logic [PW-1:0]        msb_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// offset folded in ahead of the rounding shift
			psum[i] = (W+26)'(sp_s3[i][0]) + (W+26)'(sp_s3[i][1]) + (W+26)'(sp_s3[i][2])
				+ (W+26)'(psrt_pkg::ROUND_HALF)
				+ ((W+26)'($signed(off_q[i])) <<< FW);
			prnd[i] = psum[i][W+25:FW];
			if (!prnd[i][W+9] && (|prnd[i][W+8:W-1])) begin
				psat[i] = {1'b0, {(W-1){1'b1}}};
			end else if (prnd[i][W+9] && !(&prnd[i][W+8:W-1])) begin
				psat[i] = {1'b1, {(W-1){1'b0}}};
			end else begin
				psat[i] = prnd[i][W-1:0];
			end
		end
		u_or    = u_s3[0] | u_s3[1] | u_s3[2];
		msb_pos = '0;
		for (int k = 0; k < UW; k++) begin
			if (u_or[k]) msb_pos = PW'(k);
		end
		for (int i = 0; i < 3; i++) begin
			side_d4.pos[i]  = grp_s3 ? psat[i] : p_s3[i];
			side_d4.norm[i] = (!grp_s3 && hasn_s3) ? n_s3[i] : '0;
		end
		side_d4.use_q = grp_s3 && hasn_s3 && (|u_or);
		side_d4.neg   = neg_s3;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			side_s4 <= side_d4;
			msb_s4  <= msb_pos;
			for (int i = 0; i < 3; i++) u_s4[i] <= u_s3[i];
		end
	end

	// ---------------- stage 5: bring the largest magnitude to [2^29, 2^30) ----------------
	side_t         side_s5;
	logic [NW-1:0] ush_s5 [3];

	always_ff @(posedge clk) begin
		if (ce) begin
			side_s5 <= side_s4;
			for (int i = 0; i < 3; i++) begin
				if (msb_s4 >= PW'(psrt_pkg::NORM_MSB)) begin
					ush_s5[i] <= NW'(u_s4[i] >> (msb_s4 - PW'(psrt_pkg::NORM_MSB)));
				end else begin
					ush_s5[i] <= NW'(u_s4[i]) << (PW'(psrt_pkg::NORM_MSB) - msb_s4);
				end
			end
		end
	end

	// ---------------- stage 6: squares ----------------
	side_t                     side_s6;
	logic [NW-1:0]             ush_s6 [3];
	logic [psrt_pkg::SQ_W-1:0] sq_s6 [3];

	always_ff @(posedge clk) begin
		if (ce) begin
			side_s6 <= side_s5;
			for (int i = 0; i < 3; i++) begin
				ush_s6[i] <= ush_s5[i];
				sq_s6[i]  <= psrt_pkg::SQ_W'(ush_s5[i]) * psrt_pkg::SQ_W'(ush_s5[i]);
			end
		end
	end

	// ---------------- stage 7: squared length ----------------
	side_t          side_s7;
	logic [NW-1:0]  ush_s7 [3];
	logic [L2W-1:0] l2_s7;

	always_ff @(posedge clk) begin
		if (ce) begin
			side_s7 <= side_s6;
			for (int i = 0; i < 3; i++) ush_s7[i] <= ush_s6[i];
			l2_s7 <= L2W'(sq_s6[0]) + L2W'(sq_s6[1]) + L2W'(sq_s6[2]);
		end
	end

	// ---------------- square root, one result bit per stage ----------------
	logic [L2W-1:0] rem_sq_s  [1:NSQ];
	logic [L2W-1:0] root_sq_s [1:NSQ];
	logic [NW-1:0]  u_sq_s    [1:NSQ][3];
	side_t          side_sq_s [1:NSQ];

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		localparam logic [L2W-1:0] BIT = L2W'(1) << (2*(NSQ-1-k));
		logic [L2W-1:0] rem_in, root_in, trial;
		logic [NW-1:0]  u_in [3];
		side_t          side_in;

		if (k == 0) begin : g_first
			assign rem_in  = l2_s7;
			assign root_in = '0;
			assign u_in    = ush_s7;
			assign side_in = side_s7;
		end else begin : g_next
			assign rem_in  = rem_sq_s[k];
			assign root_in = root_sq_s[k];
			assign u_in    = u_sq_s[k];
			assign side_in = side_sq_s[k];
		end

		assign trial = root_in + BIT;

		always_ff @(posedge clk) begin
			if (ce) begin
				if (rem_in >= trial) begin
					rem_sq_s[k+1]  <= rem_in - trial;
					root_sq_s[k+1] <= (root_in >> 1) + BIT;
				end else begin
					rem_sq_s[k+1]  <= rem_in;
					root_sq_s[k+1] <= root_in >> 1;
				end
				u_sq_s[k+1]    <= u_in;
				side_sq_s[k+1] <= side_in;
			end
		end
	end

	// ---------------- divide by the length, one quotient bit per stage ----------------
	logic [RW-1:0] rem_dv_s  [1:QB][3];
	logic [QB-1:0] q_dv_s    [1:QB][3];
	logic [LW-1:0] len_dv_s  [1:QB];
	side_t         side_dv_s [1:QB];

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int B = QB - 1 - j;
		logic [RW-1:0] rem_in [3];
		logic [QB-1:0] q_in [3];
		logic [LW-1:0] len_in;
		logic [RW-1:0] dsr;
		side_t         side_in;

		if (j == 0) begin : g_first
			assign len_in  = root_sq_s[NSQ][LW-1:0];
			assign side_in = side_sq_s[NSQ];
			for (genvar i = 0; i < 3; i++) begin : g_init
				// rounding by half the divisor
				assign rem_in[i] = (RW'(u_sq_s[NSQ][i]) << FW) + RW'(len_in >> 1);
				assign q_in[i]   = '0;
			end
		end else begin : g_next
			assign len_in  = len_dv_s[j];
			assign side_in = side_dv_s[j];
			assign rem_in  = rem_dv_s[j];
			assign q_in    = q_dv_s[j];
		end

		assign dsr = RW'(len_in) << B;

		always_ff @(posedge clk) begin
			if (ce) begin
				for (int i = 0; i < 3; i++) begin
					if (rem_in[i] >= dsr) begin
						rem_dv_s[j+1][i] <= rem_in[i] - dsr;
						q_dv_s[j+1][i]   <= q_in[i] | (QB'(1) << B);
					end else begin
						rem_dv_s[j+1][i] <= rem_in[i];
						q_dv_s[j+1][i]   <= q_in[i];
					end
				end
				len_dv_s[j+1]  <= len_in;
				side_dv_s[j+1] <= side_in;
			end
		end
	end

	// ---------------- output word ----------------
	logic [2:0][W-1:0] norm_d;
	logic [W-1:0]      qv [3];
	logic [6*W-1:0]    out_s;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qv[i] = W'(q_dv_s[QB][i]);
			if (side_dv_s[QB].use_q) begin
				norm_d[i] = side_dv_s[QB].neg[i] ? (W'(0) - qv[i]) : qv[i];
			end else begin
				norm_d[i] = side_dv_s[QB].norm[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			out_s <= {norm_d, side_dv_s[QB].pos};
		end
	end

	assign m_tdata = DW'(out_s);

endmodule
